// File: hw/rtl/dfls_pkg.sv
// shared types, command codes, register constants and code tables for the
// dual flash led sequencer; no dependencies
package dfls_pkg;

    localparam int LEVEL_COUNT_DEFAULT = 26;
    localparam int CHANNEL_COUNT       = 2;
    localparam int TABLE_LEN           = 26;
    localparam int QUEUE_DEPTH         = 2;

    localparam logic [4:0]  TABLE_LAST    = 5'(TABLE_LEN - 1);
    localparam logic [15:0] TORCH_LIMIT   = 16'd7;
    localparam logic [15:0] TIMEOUT_RESET = 16'd100;

    localparam logic [3:0] ENABLE_REG_ADDR = 4'h1;
    localparam logic [3:0] TIMING_REG_ADDR = 4'h8;
    localparam logic [7:0] TIMING_VAL      = 8'h1F;
    localparam logic [7:0] ENABLE_CLEAR    = 8'h00;

    typedef enum logic [2:0] {
        OP_SET_TIMEOUT = 3'd0,
        OP_SET_LEVEL   = 3'd1,
        OP_ON          = 3'd2,
        OP_OFF         = 3'd3,
        OP_GET_CURRENT = 3'd4,
        OP_TICK        = 3'd5,
        OP_POWER_UP    = 3'd6,
        OP_POWER_DOWN  = 3'd7
    } opcode_t;

    localparam logic STATUS_OK          = 1'b0;
    localparam logic STATUS_BAD_CHANNEL = 1'b1;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [1:0]  channel;
        logic [15:0] arg;
    } cmd_t;

    typedef struct packed {
        logic        write_valid;
        logic [3:0]  reg_addr;
        logic [7:0]  reg_data;
        logic [9:0]  reply_value;
        logic        hw_enable_pin;
        logic        status;
        logic        last;
    } rsp_t;

    // one queued command: first result, optional second result
    typedef struct packed {
        rsp_t first;
        rsp_t second;
        logic two;
    } q_entry_t;

    function automatic logic [3:0] torch_addr(input logic ch);
        return ch ? 4'h6 : 4'h5;
    endfunction

    function automatic logic [3:0] flash_addr(input logic ch);
        return ch ? 4'h4 : 4'h3;
    endfunction

    function automatic logic [7:0] en_bit(input logic ch);
        return ch ? 8'h02 : 8'h01;
    endfunction

    function automatic logic [7:0] en_torch(input logic ch);
        return ch ? 8'h0A : 8'h09;
    endfunction

    function automatic logic [7:0] en_flash(input logic ch);
        return ch ? 8'h0E : 8'h0D;
    endfunction

    // switch one led off; mode bits only go when the other led is off too
    function automatic logic [7:0] led_off(input logic [7:0] shadow, input logic ch);
        logic [7:0] res;
        if ((shadow & en_bit(~ch)) != 8'h00)
            res = shadow & ~en_bit(ch);
        else
            res = shadow & ~en_flash(ch);
        return res;
    endfunction

    function automatic logic [7:0] torch_code(input logic variant, input logic [4:0] idx);
        logic [7:0] res;
        case (idx)
            5'd0:    res = variant ? 8'h08 : 8'h06;
            5'd1:    res = variant ? 8'h10 : 8'h0F;
            5'd2:    res = variant ? 8'h18 : 8'h17;
            5'd3:    res = variant ? 8'h21 : 8'h1F;
            5'd4:    res = variant ? 8'h29 : 8'h27;
            5'd5:    res = variant ? 8'h31 : 8'h2F;
            5'd6:    res = variant ? 8'h3A : 8'h37;
            default: res = 8'h00;
        endcase
        return res;
    endfunction

    function automatic logic [7:0] flash_code(input logic [4:0] idx);
        logic [7:0] res;
        case (idx)
            5'd0:    res = 8'h01;
            5'd1:    res = 8'h03;
            5'd2:    res = 8'h05;
            5'd3:    res = 8'h07;
            5'd4:    res = 8'h09;
            5'd5:    res = 8'h0B;
            5'd6:    res = 8'h0D;
            5'd7:    res = 8'h10;
            5'd8:    res = 8'h13;
            5'd9:    res = 8'h17;
            5'd10:   res = 8'h1B;
            5'd11:   res = 8'h1E;
            5'd12:   res = 8'h22;
            5'd13:   res = 8'h26;
            5'd14:   res = 8'h29;
            5'd15:   res = 8'h2D;
            5'd16:   res = 8'h31;
            5'd17:   res = 8'h34;
            5'd18:   res = 8'h38;
            5'd19:   res = 8'h3C;
            5'd20:   res = 8'h40;
            5'd21:   res = 8'h44;
            5'd22:   res = 8'h48;
            5'd23:   res = 8'h4C;
            5'd24:   res = 8'h50;
            default: res = 8'h54;
        endcase
        return res;
    endfunction

    function automatic logic [9:0] current_ma(input logic variant, input logic [4:0] idx);
        logic [9:0] res;
        case (idx)
            5'd0:    res = variant ? 10'd24 : 10'd22;
            5'd1:    res = 10'd46;
            5'd2:    res = 10'd70;
            5'd3:    res = 10'd93;
            5'd4:    res = 10'd116;
            5'd5:    res = 10'd140;
            5'd6:    res = variant ? 10'd164 : 10'd163;
            5'd7:    res = variant ? 10'd199 : 10'd198;
            5'd8:    res = 10'd234;
            5'd9:    res = 10'd281;
            5'd10:   res = 10'd328;
            5'd11:   res = 10'd363;
            5'd12:   res = 10'd410;
            5'd13:   res = 10'd457;
            5'd14:   res = 10'd492;
            5'd15:   res = 10'd539;
            5'd16:   res = 10'd586;
            5'd17:   res = 10'd621;
            5'd18:   res = 10'd668;
            5'd19:   res = 10'd715;
            5'd20:   res = 10'd762;
            5'd21:   res = 10'd809;
            5'd22:   res = 10'd855;
            5'd23:   res = 10'd902;
            5'd24:   res = 10'd949;
            default: res = 10'd996;
        endcase
        return res;
    endfunction

endpackage

// File: hw/rtl/dfls_front.sv
// front end: takes commands, keeps enable shadow, levels and timers,
// and builds one queue entry per command; uses dfls_pkg
module dfls_front #(
    parameter int LEVEL_COUNT = dfls_pkg::LEVEL_COUNT_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                chip_variant,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  dfls_pkg::cmd_t      cmd,
    output logic                push,
    input  logic                push_ready,
    output dfls_pkg::q_entry_t  push_entry
);

    localparam int LW = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
    localparam logic [15:0] LEVEL_MAX = 16'(LEVEL_COUNT - 1);

    logic [7:0]    shadow_reg, shadow_next;
    logic [LW-1:0] level_reg [dfls_pkg::CHANNEL_COUNT];
    logic [LW-1:0] level_next [dfls_pkg::CHANNEL_COUNT];
    logic [15:0]   timeout_reg [dfls_pkg::CHANNEL_COUNT];
    logic [15:0]   timeout_next [dfls_pkg::CHANNEL_COUNT];
    logic [15:0]   countdown_reg [dfls_pkg::CHANNEL_COUNT];
    logic [15:0]   countdown_next [dfls_pkg::CHANNEL_COUNT];
    logic [1:0]    running_reg, running_next;
    logic          pin_reg, pin_next;

    logic          sel;
    logic [15:0]   lvl_clamped;
    logic [4:0]    tbl_idx;
    logic [15:0]   cd_dec0, cd_dec1;
    logic          exp0, exp1;
    logic [7:0]    sh_a, sh_b;
    dfls_pkg::rsp_t r0, r1;
    logic          two;

    function automatic dfls_pkg::rsp_t mk_write(input logic [3:0] addr, input logic [7:0] data);
        dfls_pkg::rsp_t r;
        r = '0;
        r.write_valid = 1'b1;
        r.reg_addr    = addr;
        r.reg_data    = data;
        return r;
    endfunction

    assign cmd_ready = push_ready;
    assign push      = cmd_valid && push_ready;
    assign sel       = cmd.channel[0];

    assign lvl_clamped = (cmd.arg >= LEVEL_MAX) ? LEVEL_MAX : cmd.arg;
    assign tbl_idx     = (lvl_clamped >= 16'(dfls_pkg::TABLE_LAST))
                         ? dfls_pkg::TABLE_LAST : lvl_clamped[4:0];

    // tick: timers count down, channel 0 expires first
    assign cd_dec0 = (countdown_reg[0] != 16'd0) ? countdown_reg[0] - 16'd1 : 16'd0;
    assign cd_dec1 = (countdown_reg[1] != 16'd0) ? countdown_reg[1] - 16'd1 : 16'd0;
    assign exp0    = running_reg[0] && (cd_dec0 == 16'd0);
    assign exp1    = running_reg[1] && (cd_dec1 == 16'd0);
    assign sh_a    = exp0 ? dfls_pkg::led_off(shadow_reg, 1'b0) : shadow_reg;
    assign sh_b    = exp1 ? dfls_pkg::led_off(sh_a, 1'b1) : sh_a;

    always_comb
    begin
        shadow_next  = shadow_reg;
        level_next   = level_reg;
        timeout_next = timeout_reg;
        countdown_next = countdown_reg;
        running_next = running_reg;
        pin_next     = pin_reg;
        r0           = '0;
        r1           = '0;
        two          = 1'b0;

        if (cmd.channel[1] && (cmd.opcode <= 3'(dfls_pkg::OP_GET_CURRENT)))
        begin
            r0.status = dfls_pkg::STATUS_BAD_CHANNEL;
        end
        else
        begin
            unique case (dfls_pkg::opcode_t'(cmd.opcode))
                dfls_pkg::OP_SET_TIMEOUT:
                begin
                    timeout_next[sel] = cmd.arg;
                end
                dfls_pkg::OP_SET_LEVEL:
                begin
                    level_next[sel] = lvl_clamped[LW-1:0];
                    r0  = mk_write(dfls_pkg::torch_addr(sel),
                                   dfls_pkg::torch_code(chip_variant, tbl_idx));
                    r1  = mk_write(dfls_pkg::flash_addr(sel), dfls_pkg::flash_code(tbl_idx));
                    two = 1'b1;
                end
                dfls_pkg::OP_ON:
                begin
                    if (timeout_reg[sel] != 16'd0)
                    begin
                        countdown_next[sel] = timeout_reg[sel];
                        running_next[sel]   = 1'b1;
                    end
                    if (16'(level_reg[sel]) < dfls_pkg::TORCH_LIMIT)
                        shadow_next = shadow_reg | dfls_pkg::en_torch(sel);
                    else
                        shadow_next = shadow_reg | dfls_pkg::en_flash(sel);
                    r0 = mk_write(dfls_pkg::ENABLE_REG_ADDR, shadow_next);
                end
                dfls_pkg::OP_OFF:
                begin
                    shadow_next         = dfls_pkg::led_off(shadow_reg, sel);
                    running_next[sel]   = 1'b0;
                    countdown_next[sel] = 16'd0;
                    r0 = mk_write(dfls_pkg::ENABLE_REG_ADDR, shadow_next);
                end
                dfls_pkg::OP_GET_CURRENT:
                begin
                    r0.reply_value = dfls_pkg::current_ma(chip_variant, tbl_idx);
                end
                dfls_pkg::OP_TICK:
                begin
                    if (running_reg[0]) countdown_next[0] = cd_dec0;
                    if (running_reg[1]) countdown_next[1] = cd_dec1;
                    if (exp0) running_next[0] = 1'b0;
                    if (exp1) running_next[1] = 1'b0;
                    shadow_next = sh_b;
                    if (exp0 && exp1)
                    begin
                        r0  = mk_write(dfls_pkg::ENABLE_REG_ADDR, sh_a);
                        r1  = mk_write(dfls_pkg::ENABLE_REG_ADDR, sh_b);
                        two = 1'b1;
                    end
                    else if (exp0 || exp1)
                    begin
                        r0 = mk_write(dfls_pkg::ENABLE_REG_ADDR, sh_b);
                    end
                end
                dfls_pkg::OP_POWER_UP:
                begin
                    pin_next    = 1'b1;
                    shadow_next = dfls_pkg::ENABLE_CLEAR;
                    r0  = mk_write(dfls_pkg::ENABLE_REG_ADDR, dfls_pkg::ENABLE_CLEAR);
                    r1  = mk_write(dfls_pkg::TIMING_REG_ADDR, dfls_pkg::TIMING_VAL);
                    two = 1'b1;
                end
                dfls_pkg::OP_POWER_DOWN:
                begin
                    pin_next    = 1'b0;
                    shadow_next = dfls_pkg::led_off(dfls_pkg::led_off(shadow_reg, 1'b0), 1'b1);
                    r0  = mk_write(dfls_pkg::ENABLE_REG_ADDR,
                                   dfls_pkg::led_off(shadow_reg, 1'b0));
                    r1  = mk_write(dfls_pkg::ENABLE_REG_ADDR, shadow_next);
                    two = 1'b1;
                end
                default:
                begin
                    r0 = '0;
                end
            endcase
        end

        // pin level after the command is reported in every result
        r0.hw_enable_pin = pin_next;
        r1.hw_enable_pin = pin_next;
        r0.last          = ~two;
        r1.last          = 1'b1;
    end

    assign push_entry.first  = r0;
    assign push_entry.second = r1;
    assign push_entry.two    = two;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_reg  <= 8'h00;
            running_reg <= 2'b00;
            pin_reg     <= 1'b0;
            for (int i = 0; i < dfls_pkg::CHANNEL_COUNT; i++)
            begin
                level_reg[i]     <= '0;
                timeout_reg[i]   <= dfls_pkg::TIMEOUT_RESET;
                countdown_reg[i] <= 16'd0;
            end
        end
        else if (push)
        begin
            shadow_reg    <= shadow_next;
            level_reg     <= level_next;
            timeout_reg   <= timeout_next;
            countdown_reg <= countdown_next;
            running_reg   <= running_next;
            pin_reg       <= pin_next;
        end
    end

endmodule

// File: hw/rtl/dfls_queue.sv
// short command queue between front and back end; uses dfls_pkg
module dfls_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                push_ready,
    input  dfls_pkg::q_entry_t  push_entry,
    output logic                pop_valid,
    input  logic                pop,
    output dfls_pkg::q_entry_t  pop_entry
);

    localparam int PW = (dfls_pkg::QUEUE_DEPTH > 1) ? $clog2(dfls_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(dfls_pkg::QUEUE_DEPTH + 1);

    dfls_pkg::q_entry_t entry_reg [dfls_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_pop;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(dfls_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign push_ready = (count_reg != CW'(dfls_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_pop     = pop && pop_valid;
    assign pop_entry  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CW'(push) - CW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

// File: hw/rtl/dfls_back.sv
// back end: plays out one or two results per queued command through
// the output register; uses dfls_pkg
module dfls_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    output logic                pop,
    input  dfls_pkg::q_entry_t  pop_entry,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output dfls_pkg::rsp_t      rsp
);

    logic           out_valid_reg, out_valid_next;
    dfls_pkg::rsp_t out_reg, out_next;
    logic           pend_reg, pend_next;
    dfls_pkg::rsp_t second_reg, second_next;
    logic           can_load;

    assign can_load = !out_valid_reg || rsp_ready;
    assign pop      = can_load && !pend_reg && pop_valid;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        pend_next      = pend_reg;
        second_next    = second_reg;
        if (can_load)
        begin
            if (pend_reg)
            begin
                out_next       = second_reg;
                out_valid_next = 1'b1;
                pend_next      = 1'b0;
            end
            else if (pop_valid)
            begin
                out_next       = pop_entry.first;
                out_valid_next = 1'b1;
                pend_next      = pop_entry.two;
                second_next    = pop_entry.second;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg    <= out_next;
        second_reg <= second_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

// File: hw/rtl/dual_flash_led_sequencer.sv
// top level of the dual flash led sequencer: chip variant register,
// front end, command queue and back end; uses dfls_pkg and the dfls modules
//
// Each cmd item is one driver command (set timeout, set level, on, off,
// current query, 1 ms tick, power up, power down) and gives one or two rsp
// items; the last one of a command has last set. The front end accepts a
// command whenever the two-entry queue has room, updates the enable
// shadow, levels and timers at once, and queues the finished results.
// The back end drives them out through its single output register, one rsp
// item per cycle while rsp_ready is high, so a two-result command (set level,
// power up, power down, a tick where both timers run out) holds back the
// next queued command until its second result is loaded. A command's
// results pass through the queue and the output register. chip_variant
// selects the torch and current tables and must be written only while no
// command is in flight.
module dual_flash_led_sequencer #(
    parameter int LEVEL_COUNT = dfls_pkg::LEVEL_COUNT_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    // command channel
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  dfls_pkg::cmd_t  cmd,
    // result channel
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output dfls_pkg::rsp_t  rsp,
    // chip variant register write
    input  logic            cfg_wr_en,
    input  logic            cfg_wr_data
);

    logic               chip_variant_reg;
    logic               push, push_ready;
    dfls_pkg::q_entry_t push_entry;
    logic               pop_valid, pop;
    dfls_pkg::q_entry_t pop_entry;

    // configuration register, no read-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            chip_variant_reg <= 1'b0;
        else if (cfg_wr_en)
            chip_variant_reg <= cfg_wr_data;
    end

    // front end: command decode and all driver state
    dfls_front #(
        .LEVEL_COUNT (LEVEL_COUNT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .chip_variant (chip_variant_reg),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd),
        .push         (push),
        .push_ready   (push_ready),
        .push_entry   (push_entry)
    );

    // decouples command intake from result delivery
    dfls_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_entry  (pop_entry)
    );

    // back end: one result item per cycle into the output register while it is empty or rsp_ready is high
    dfls_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop       (pop),
        .pop_entry (pop_entry),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule
